[src/plb_pkg.sv]
// ----------------------------------------------------------------------------
// plb_pkg
// Types, codes and widths shared by the page buffer manager modules.
// ----------------------------------------------------------------------------
package plb_pkg;

	localparam int HANDLE_BITS = 16;
	localparam int PAGE_BITS   = 40;
	localparam int PIN_BITS    = 8;
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	// request commands
	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_REF   = 3'd1;
	localparam logic [2:0] CMD_TOUCH = 3'd2;
	localparam logic [2:0] CMD_REL   = 3'd3;
	localparam logic [2:0] CMD_SWAP  = 3'd4;
	localparam logic [2:0] CMD_FLUSH = 3'd5;
	localparam logic [2:0] CMD_PURGE = 3'd6;
	localparam logic [2:0] CMD_TRUNC = 3'd7;

	// result actions and status
	localparam logic [1:0] ACT_DONE = 2'd0;
	localparam logic [1:0] ACT_WB   = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	// slot table read select
	localparam logic [2:0] SEL_IDX   = 3'd0;
	localparam logic [2:0] SEL_A     = 3'd1;
	localparam logic [2:0] SEL_B     = 3'd2;
	localparam logic [2:0] SEL_FOUND = 3'd3;
	localparam logic [2:0] SEL_VIC   = 3'd4;

	// slot table write operations, applied at the selected slot
	localparam logic [2:0] WR_NONE    = 3'd0;
	localparam logic [2:0] WR_PIN_INC = 3'd1;
	localparam logic [2:0] WR_TOUCH   = 3'd2;
	localparam logic [2:0] WR_RELEASE = 3'd3;
	localparam logic [2:0] WR_FILL    = 3'd4;
	localparam logic [2:0] WR_SWAP    = 3'd5;
	localparam logic [2:0] WR_CLEAN   = 3'd6;
	localparam logic [2:0] WR_EVICT   = 3'd7;

	// result kinds
	localparam logic [2:0] EM_HIT  = 3'd0;
	localparam logic [2:0] EM_FULL = 3'd1;
	localparam logic [2:0] EM_SLOT = 3'd2;
	localparam logic [2:0] EM_BAD  = 3'd3;
	localparam logic [2:0] EM_HDL  = 3'd4;
	localparam logic [2:0] EM_WB   = 3'd5;
	localparam logic [2:0] EM_READ = 3'd6;

	typedef struct packed {
		logic [2:0]             cmd;
		logic [HANDLE_BITS-1:0] file_handle;
		logic [PAGE_BITS-1:0]   page_number;
		logic [4:0]             slot;
		logic [4:0]             other_slot;
		logic                   mark_dirty;
	} req_t;

	typedef struct packed {
		logic [1:0]             action;
		logic [4:0]             slot_res;
		logic [HANDLE_BITS-1:0] file_handle_res;
		logic [PAGE_BITS-1:0]   page_number_res;
		logic                   hit;
		logic [1:0]             status;
		logic                   last;
	} res_t;

	typedef struct packed {
		logic       take_req;
		logic       idx_inc;
		logic       scan_step;
		logic       rank_bump;
		logic       tmp_load;
		logic [2:0] rsel;
		logic [2:0] wr_op;
		logic       emit;
		logic [2:0] emit_kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       bad;
		logic       found_v;
		logic       vic_v;
		logic       wb_need;
		logic       walk_sel;
		logic       idx_last;
		logic       can_emit;
	} dp_stat_t;

endpackage

[src/plb_dp.sv]
// ----------------------------------------------------------------------------
// plb_dp
// Slot table, scan index, load search registers and result register.
// ----------------------------------------------------------------------------
module plb_dp #(
	parameter int SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plb_pkg::req_t      req_data,
	input  logic               res_stall,
	input  plb_pkg::ctrl_cmd_t cmd_in,
	output plb_pkg::dp_stat_t  stat,
	output logic               res_valid,
	output plb_pkg::res_t      res_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                            valid_q [SLOTS];
	logic [plb_pkg::HANDLE_BITS-1:0] handle_q[SLOTS];
	logic [plb_pkg::PAGE_BITS-1:0]   page_q  [SLOTS];
	logic [plb_pkg::PIN_BITS-1:0]    pins_q  [SLOTS];
	logic                            dirty_q [SLOTS];
	logic [IW-1:0]                   rank_q  [SLOTS];

	plb_pkg::req_t                 req_q;
	logic [IW-1:0]                 idx_q;
	logic                          found_v_q;
	logic [IW-1:0]                 found_q;
	logic                          vic_v_q;
	logic [IW-1:0]                 vic_q;
	logic [IW-1:0]                 vic_rank_q;
	logic [plb_pkg::PAGE_BITS-1:0] tmp_page_q;
	logic [plb_pkg::PIN_BITS-1:0]  tmp_pins_q;
	logic                          res_valid_q;
	plb_pkg::res_t                 res_q;

	logic [IW-1:0]                   rix;
	logic                            rd_valid;
	logic [plb_pkg::HANDLE_BITS-1:0] rd_handle;
	logic [plb_pkg::PAGE_BITS-1:0]   rd_page;
	logic [plb_pkg::PIN_BITS-1:0]    rd_pins;
	logic                            rd_dirty;
	logic [IW-1:0]                   rd_rank;
	logic                            can_emit;
	plb_pkg::res_t                   res_nx;

	always_comb begin
		unique case (cmd_in.rsel)
			plb_pkg::SEL_A:     rix = req_q.slot[IW-1:0];
			plb_pkg::SEL_B:     rix = req_q.other_slot[IW-1:0];
			plb_pkg::SEL_FOUND: rix = found_q;
			plb_pkg::SEL_VIC:   rix = vic_q;
			default:            rix = idx_q;
		endcase
	end

	assign rd_valid  = valid_q[rix];
	assign rd_handle = handle_q[rix];
	assign rd_page   = page_q[rix];
	assign rd_pins   = pins_q[rix];
	assign rd_dirty  = dirty_q[rix];
	assign rd_rank   = rank_q[rix];

	assign can_emit = !res_valid_q || !res_stall;

	assign stat.cmd      = req_q.cmd;
	assign stat.bad      = ({1'b0, req_q.slot} >= 6'(SLOTS)) ||
		((req_q.cmd == plb_pkg::CMD_SWAP) && ({1'b0, req_q.other_slot} >= 6'(SLOTS)));
	assign stat.found_v  = found_v_q;
	assign stat.vic_v    = vic_v_q;
	assign stat.wb_need  = rd_valid && rd_dirty;
	assign stat.walk_sel = rd_valid && (rd_handle == req_q.file_handle) &&
		((req_q.cmd != plb_pkg::CMD_TRUNC) || (rd_page >= req_q.page_number));
	assign stat.idx_last = (idx_q == IW'(SLOTS - 1));
	assign stat.can_emit = can_emit;

	// slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i]  <= 1'b0;
				handle_q[i] <= '0;
				page_q[i]   <= '0;
				pins_q[i]   <= '0;
				dirty_q[i]  <= 1'b0;
				rank_q[i]   <= IW'(i);
			end
		end else begin
			if (cmd_in.rank_bump) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (rank_q[i] < vic_rank_q)
						rank_q[i] <= rank_q[i] + 1'b1;
				end
				rank_q[vic_q] <= '0;
			end
			case (cmd_in.wr_op)
				plb_pkg::WR_PIN_INC: begin
					if (rd_pins != plb_pkg::PIN_MAX)
						pins_q[rix] <= rd_pins + 1'b1;
				end
				plb_pkg::WR_TOUCH: dirty_q[rix] <= 1'b1;
				plb_pkg::WR_RELEASE: begin
					if (rd_pins != '0)
						pins_q[rix] <= rd_pins - 1'b1;
					if (req_q.mark_dirty)
						dirty_q[rix] <= 1'b1;
				end
				plb_pkg::WR_FILL: begin
					valid_q[rix]  <= 1'b1;
					handle_q[rix] <= req_q.file_handle;
					page_q[rix]   <= req_q.page_number;
					pins_q[rix]   <= plb_pkg::PIN_BITS'(1);
					dirty_q[rix]  <= 1'b0;
				end
				plb_pkg::WR_SWAP: begin
					page_q[rix]  <= tmp_page_q;
					pins_q[rix]  <= tmp_pins_q;
					dirty_q[rix] <= 1'b1;
				end
				plb_pkg::WR_CLEAN: dirty_q[rix] <= 1'b0;
				plb_pkg::WR_EVICT: begin
					valid_q[rix]  <= 1'b0;
					handle_q[rix] <= '0;
					page_q[rix]   <= '0;
					pins_q[rix]   <= '0;
					dirty_q[rix]  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// request, scan index and load search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			found_v_q <= 1'b0;
			vic_v_q   <= 1'b0;
		end else if (cmd_in.take_req) begin
			idx_q     <= '0;
			found_v_q <= 1'b0;
			vic_v_q   <= 1'b0;
		end else begin
			if (cmd_in.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd_in.scan_step) begin
				if (rd_valid && !found_v_q && (rd_handle == req_q.file_handle) &&
					(rd_page == req_q.page_number))
					found_v_q <= 1'b1;
				if ((rd_pins == '0) && (!vic_v_q || (rd_rank > vic_rank_q)))
					vic_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.take_req)
			req_q <= req_data;
		if (cmd_in.scan_step) begin
			if (rd_valid && !found_v_q && (rd_handle == req_q.file_handle) &&
				(rd_page == req_q.page_number))
				found_q <= rix;
			if ((rd_pins == '0) && (!vic_v_q || (rd_rank > vic_rank_q))) begin
				vic_q      <= rix;
				vic_rank_q <= rd_rank;
			end
		end
		if (cmd_in.tmp_load) begin
			tmp_page_q <= rd_page;
			tmp_pins_q <= rd_pins;
		end
	end

	// result formatting
	always_comb begin
		res_nx        = '0;
		res_nx.action = plb_pkg::ACT_DONE;
		res_nx.status = plb_pkg::ST_OK;
		res_nx.last   = 1'b1;
		case (cmd_in.emit_kind)
			plb_pkg::EM_HIT: begin
				res_nx.slot_res        = 5'(found_q);
				res_nx.file_handle_res = req_q.file_handle;
				res_nx.page_number_res = req_q.page_number;
				res_nx.hit             = 1'b1;
			end
			plb_pkg::EM_FULL: begin
				res_nx.file_handle_res = req_q.file_handle;
				res_nx.page_number_res = req_q.page_number;
				res_nx.status          = plb_pkg::ST_FULL;
			end
			plb_pkg::EM_SLOT: res_nx.slot_res = req_q.slot;
			plb_pkg::EM_BAD: begin
				res_nx.slot_res = req_q.slot;
				res_nx.status   = plb_pkg::ST_BAD;
			end
			plb_pkg::EM_HDL: res_nx.file_handle_res = req_q.file_handle;
			plb_pkg::EM_WB: begin
				res_nx.action          = plb_pkg::ACT_WB;
				res_nx.slot_res        = 5'(rix);
				res_nx.file_handle_res = rd_handle;
				res_nx.page_number_res = rd_page;
				res_nx.last            = 1'b0;
			end
			plb_pkg::EM_READ: begin
				res_nx.action          = plb_pkg::ACT_READ;
				res_nx.slot_res        = 5'(vic_q);
				res_nx.file_handle_res = req_q.file_handle;
				res_nx.page_number_res = req_q.page_number;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_in.emit && can_emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.emit && can_emit)
			res_q <= res_nx;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

[src/plb_ctrl.sv]
// ----------------------------------------------------------------------------
// plb_ctrl
// Command sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module plb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               busy,
	input  plb_pkg::dp_stat_t  stat,
	output plb_pkg::ctrl_cmd_t cmd_out
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_LDEC  = 4'd3;
	localparam logic [3:0] S_LEV   = 4'd4;
	localparam logic [3:0] S_LFILL = 4'd5;
	localparam logic [3:0] S_SW1   = 4'd6;
	localparam logic [3:0] S_SW2   = 4'd7;
	localparam logic [3:0] S_SW3   = 4'd8;
	localparam logic [3:0] S_WALK  = 4'd9;
	localparam logic [3:0] S_WDONE = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       wb;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd_out  = '0;
		cmd_out.rsel  = plb_pkg::SEL_IDX;
		cmd_out.wr_op = plb_pkg::WR_NONE;
		state_nx = state_q;
		wb       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_out.take_req = 1'b1;
					state_nx = S_DEC;
				end
			end
			S_DEC: begin
				cmd_out.rsel = plb_pkg::SEL_A;
				unique case (stat.cmd) inside
					plb_pkg::CMD_LOAD: state_nx = S_SCAN;
					plb_pkg::CMD_FLUSH, plb_pkg::CMD_PURGE, plb_pkg::CMD_TRUNC:
						state_nx = S_WALK;
					default: begin
						if (stat.bad) begin
							cmd_out.emit      = 1'b1;
							cmd_out.emit_kind = plb_pkg::EM_BAD;
							if (stat.can_emit)
								state_nx = S_IDLE;
						end else if (stat.cmd == plb_pkg::CMD_SWAP) begin
							state_nx = S_SW1;
						end else begin
							cmd_out.emit      = 1'b1;
							cmd_out.emit_kind = plb_pkg::EM_SLOT;
							if (stat.can_emit) begin
								unique case (stat.cmd)
									plb_pkg::CMD_REF:   cmd_out.wr_op = plb_pkg::WR_PIN_INC;
									plb_pkg::CMD_TOUCH: cmd_out.wr_op = plb_pkg::WR_TOUCH;
									default:            cmd_out.wr_op = plb_pkg::WR_RELEASE;
								endcase
								state_nx = S_IDLE;
							end
						end
					end
				endcase
			end
			S_SCAN: begin
				cmd_out.scan_step = 1'b1;
				cmd_out.idx_inc   = 1'b1;
				if (stat.idx_last)
					state_nx = S_LDEC;
			end
			S_LDEC: begin
				cmd_out.rsel = plb_pkg::SEL_FOUND;
				if (stat.found_v) begin
					cmd_out.emit      = 1'b1;
					cmd_out.emit_kind = plb_pkg::EM_HIT;
					if (stat.can_emit) begin
						cmd_out.wr_op = plb_pkg::WR_PIN_INC;
						state_nx = S_IDLE;
					end
				end else if (!stat.vic_v) begin
					cmd_out.emit      = 1'b1;
					cmd_out.emit_kind = plb_pkg::EM_FULL;
					if (stat.can_emit)
						state_nx = S_IDLE;
				end else begin
					cmd_out.rank_bump = 1'b1;
					state_nx = S_LEV;
				end
			end
			S_LEV: begin
				cmd_out.rsel = plb_pkg::SEL_VIC;
				if (stat.wb_need) begin
					cmd_out.emit      = 1'b1;
					cmd_out.emit_kind = plb_pkg::EM_WB;
				end
				if (!stat.wb_need || stat.can_emit)
					state_nx = S_LFILL;
			end
			S_LFILL: begin
				cmd_out.rsel      = plb_pkg::SEL_VIC;
				cmd_out.emit      = 1'b1;
				cmd_out.emit_kind = plb_pkg::EM_READ;
				if (stat.can_emit) begin
					cmd_out.wr_op = plb_pkg::WR_FILL;
					state_nx = S_IDLE;
				end
			end
			S_SW1: begin
				cmd_out.rsel     = plb_pkg::SEL_A;
				cmd_out.tmp_load = 1'b1;
				state_nx = S_SW2;
			end
			S_SW2: begin
				cmd_out.rsel     = plb_pkg::SEL_B;
				cmd_out.tmp_load = 1'b1;
				cmd_out.wr_op    = plb_pkg::WR_SWAP;
				state_nx = S_SW3;
			end
			S_SW3: begin
				cmd_out.rsel      = plb_pkg::SEL_A;
				cmd_out.emit      = 1'b1;
				cmd_out.emit_kind = plb_pkg::EM_SLOT;
				if (stat.can_emit) begin
					cmd_out.wr_op = plb_pkg::WR_SWAP;
					state_nx = S_IDLE;
				end
			end
			S_WALK: begin
				wb = stat.walk_sel && stat.wb_need;
				if (wb) begin
					cmd_out.emit      = 1'b1;
					cmd_out.emit_kind = plb_pkg::EM_WB;
				end
				if (!wb || stat.can_emit) begin
					if (stat.walk_sel)
						cmd_out.wr_op = (stat.cmd == plb_pkg::CMD_FLUSH) ?
							plb_pkg::WR_CLEAN : plb_pkg::WR_EVICT;
					cmd_out.idx_inc = 1'b1;
					if (stat.idx_last)
						state_nx = S_WDONE;
				end
			end
			S_WDONE: begin
				cmd_out.emit      = 1'b1;
				cmd_out.emit_kind = plb_pkg::EM_HDL;
				if (stat.can_emit)
					state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[src/pinned_lru_page_buffer_manager_core.sv]
// ----------------------------------------------------------------------------
// pinned_lru_page_buffer_manager_core
// LRU page buffer manager with pin counts, dirty marks and write-back.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on req_valid/req_stall/req_data; a request is taken when
//    req_valid is high and req_stall low. One request is in work at a time;
//    req_stall stays high until its final result is in the result register.
//  - Results leave on res_valid/res_stall/res_data. A request yields zero or
//    more write-back results (last = 0) and one final result (last = 1).
//  - Reference, touch, release and a bad slot finish from the decode state;
//    swap steps through states SW1, SW2 and SW3. Load scans the slot table
//    one slot a cycle, then emits a hit, a full pool or, on a miss, a read-in
//    after any write-back of the victim. Flush, purge and truncate walk all
//    slots and wait on each write-back that the receiver stalls.
//  - A stalled result holds in the output register; any step that must emit
//    another result waits until it is taken.
//  - Reset clears all slots, sets the recency order to slot index order and
//    empties the result register.
// ----------------------------------------------------------------------------
module pinned_lru_page_buffer_manager_core #(
	parameter int SLOTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  plb_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_stall,
	output plb_pkg::res_t res_data
);

	plb_pkg::ctrl_cmd_t ctrl_cmd;
	plb_pkg::dp_stat_t  dp_stat;
	logic               busy;

	// sequencer
	plb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.busy      (busy),
		.stat      (dp_stat),
		.cmd_out   (ctrl_cmd)
	);

	// slot table and result register
	plb_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.res_stall (res_stall),
		.cmd_in    (ctrl_cmd),
		.stat      (dp_stat),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// a request is only taken when idle
	assign req_stall = busy;

	// an accepted request keeps the input closed in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request input open right after a take");

	// write-back results are never final
	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.action == plb_pkg::ACT_WB) |-> !res_data.last)
		else $error("write-back result flagged last");

	// read-in results are final, ok and not a hit
	a_read_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.action == plb_pkg::ACT_READ) |->
		res_data.last && !res_data.hit && (res_data.status == plb_pkg::ST_OK))
		else $error("malformed read-in result");

endmodule

[tb/sv/tb_pinned_lru_page_buffer_manager_core.sv]
// ----------------------------------------------------------------------------
// tb_pinned_lru_page_buffer_manager_core
// Self-checking bench for the page buffer manager: a directed request table,
// then mostly load/pin/release traffic on a small page pool plus noise. Every
// result is compared against a cycle-free model of the slot table.
// ----------------------------------------------------------------------------
module tb_pinned_lru_page_buffer_manager_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 32;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	plb_pkg::req_t req_data;
	logic res_valid;
	logic res_stall;
	plb_pkg::res_t res_data;

	pinned_lru_page_buffer_manager_core #(.SLOTS(NSLOT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow slot table
	logic                            pool_valid [NSLOT];
	logic [plb_pkg::HANDLE_BITS-1:0] pool_handle[NSLOT];
	logic [plb_pkg::PAGE_BITS-1:0]   pool_page  [NSLOT];
	logic [7:0]                      pool_pins  [NSLOT];
	logic                            pool_dirty [NSLOT];
	logic [4:0]                      pool_rank  [NSLOT];

	plb_pkg::res_t pending_results[$];
	int   fails;
	int   cycles;
	int   send_idle_pct;
	int   recv_stall_pct;

	function automatic plb_pkg::res_t mk_res(logic [1:0] act, logic [4:0] s,
			logic [plb_pkg::HANDLE_BITS-1:0] h, logic [plb_pkg::PAGE_BITS-1:0] p,
			logic ht, logic [1:0] st, logic lst);
		plb_pkg::res_t r;
		r.action = act; r.slot_res = s; r.file_handle_res = h;
		r.page_number_res = p; r.hit = ht; r.status = st; r.last = lst;
		return r;
	endfunction

	task automatic reset_pool();
		for (int i = 0; i < NSLOT; i++) begin
			pool_valid[i] = 0; pool_handle[i] = '0; pool_page[i] = '0;
			pool_pins[i] = '0; pool_dirty[i] = 0; pool_rank[i] = 5'(i);
		end
	endtask

	// drop slot i, posting a write-back when it holds dirty data
	task automatic drop_slot(int i);
		if (pool_valid[i] && pool_dirty[i])
			pending_results.push_back(mk_res(plb_pkg::ACT_WB, 5'(i), pool_handle[i],
				pool_page[i], 0, plb_pkg::ST_OK, 0));
		pool_valid[i] = 0; pool_handle[i] = '0; pool_page[i] = '0;
		pool_pins[i] = '0; pool_dirty[i] = 0;
	endtask

	// apply one request to the shadow table and queue what it yields
	task automatic predict_request(plb_pkg::req_t q);
		int found, victim;
		logic [7:0] tpins;
		logic [plb_pkg::PAGE_BITS-1:0] tpage;
		logic [4:0] vr;
		found = -1;
		victim = -1;
		if (q.cmd == plb_pkg::CMD_LOAD) begin
			for (int i = 0; i < NSLOT; i++)
				if (found < 0 && pool_valid[i] && pool_handle[i] == q.file_handle
						&& pool_page[i] == q.page_number)
					found = i;
			if (found >= 0) begin
				if (pool_pins[found] != plb_pkg::PIN_MAX) pool_pins[found]++;
				pending_results.push_back(mk_res(plb_pkg::ACT_DONE, 5'(found),
					q.file_handle, q.page_number, 1, plb_pkg::ST_OK, 1));
				return;
			end
			for (int i = 0; i < NSLOT; i++)
				if (pool_pins[i] == 0 && (victim < 0 || pool_rank[i] > pool_rank[victim]))
					victim = i;
			if (victim < 0) begin
				pending_results.push_back(mk_res(plb_pkg::ACT_DONE, 0, q.file_handle,
					q.page_number, 0, plb_pkg::ST_FULL, 1));
				return;
			end
			vr = pool_rank[victim];
			for (int i = 0; i < NSLOT; i++)
				if (pool_rank[i] < vr) pool_rank[i]++;
			pool_rank[victim] = '0;
			drop_slot(victim);
			pool_valid[victim] = 1; pool_handle[victim] = q.file_handle;
			pool_page[victim] = q.page_number; pool_pins[victim] = 8'd1;
			pending_results.push_back(mk_res(plb_pkg::ACT_READ, 5'(victim), q.file_handle,
				q.page_number, 0, plb_pkg::ST_OK, 1));
		end else if (q.cmd <= plb_pkg::CMD_SWAP) begin
			if (q.slot >= NSLOT ||
					(q.cmd == plb_pkg::CMD_SWAP && q.other_slot >= NSLOT)) begin
				pending_results.push_back(mk_res(plb_pkg::ACT_DONE, q.slot, 0, 0, 0,
					plb_pkg::ST_BAD, 1));
				return;
			end
			case (q.cmd)
				plb_pkg::CMD_REF: begin
					if (pool_pins[q.slot] != plb_pkg::PIN_MAX) pool_pins[q.slot]++;
				end
				plb_pkg::CMD_TOUCH: pool_dirty[q.slot] = 1;
				plb_pkg::CMD_REL: begin
					if (pool_pins[q.slot] != 0) pool_pins[q.slot]--;
					if (q.mark_dirty) pool_dirty[q.slot] = 1;
				end
				default: begin
					tpage = pool_page[q.slot]; tpins = pool_pins[q.slot];
					pool_page[q.slot] = pool_page[q.other_slot];
					pool_pins[q.slot] = pool_pins[q.other_slot];
					pool_page[q.other_slot] = tpage;
					pool_pins[q.other_slot] = tpins;
					pool_dirty[q.slot] = 1; pool_dirty[q.other_slot] = 1;
				end
			endcase
			pending_results.push_back(mk_res(plb_pkg::ACT_DONE, q.slot, 0, 0, 0,
				plb_pkg::ST_OK, 1));
		end else begin
			for (int i = 0; i < NSLOT; i++) begin
				if (pool_valid[i] && pool_handle[i] == q.file_handle) begin
					if (q.cmd == plb_pkg::CMD_FLUSH) begin
						if (pool_dirty[i]) begin
							pending_results.push_back(mk_res(plb_pkg::ACT_WB, 5'(i),
								pool_handle[i], pool_page[i], 0, plb_pkg::ST_OK, 0));
							pool_dirty[i] = 0;
						end
					end else if (q.cmd == plb_pkg::CMD_PURGE ||
							pool_page[i] >= q.page_number)
						drop_slot(i);
				end
			end
			pending_results.push_back(mk_res(plb_pkg::ACT_DONE, 0, q.file_handle, 0, 0,
				plb_pkg::ST_OK, 1));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		plb_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res_data);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (res_data !== want) begin
					$display("%0t: mismatch expected %h actual %h", $time, want, res_data);
					fails++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) res_stall <= 1'b0;
		else res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic plb_pkg::req_t mk_req(logic [2:0] c,
			logic [plb_pkg::HANDLE_BITS-1:0] h, logic [plb_pkg::PAGE_BITS-1:0] p,
			logic [4:0] a, logic [4:0] b, logic md);
		plb_pkg::req_t q;
		q.cmd = c; q.file_handle = h; q.page_number = p;
		q.slot = a; q.other_slot = b; q.mark_dirty = md;
		return q;
	endfunction

	// hand one request over, idling beforehand at the current rate;
	// valid stays up after the take so the next request can follow directly
	task automatic send_request(plb_pkg::req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_request(q);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// mostly a small working set so hits, pins and evictions interplay
	function automatic plb_pkg::req_t random_request();
		plb_pkg::req_t q;
		q = plb_pkg::req_t'($bits(plb_pkg::req_t)'({$urandom, $urandom, $urandom}));
		if ($urandom_range(9) < 8) begin
			q.file_handle = 16'($urandom_range(2));
			q.page_number = 40'($urandom_range(40));
			q.slot        = 5'($urandom_range(NSLOT - 1));
			q.other_slot  = 5'($urandom_range(NSLOT - 1));
			case ($urandom_range(15))
				0,1,2,3,4,5: q.cmd = plb_pkg::CMD_LOAD;
				6,7,8,9:     q.cmd = plb_pkg::CMD_REL;
				10:          q.cmd = plb_pkg::CMD_REF;
				11:          q.cmd = plb_pkg::CMD_TOUCH;
				12:          q.cmd = plb_pkg::CMD_SWAP;
				13:          q.cmd = plb_pkg::CMD_FLUSH;
				14:          q.cmd = plb_pkg::CMD_PURGE;
				default:     q.cmd = plb_pkg::CMD_TRUNC;
			endcase
		end
		return q;
	endfunction

	typedef struct {
		plb_pkg::req_t q;
		logic has_res;
		plb_pkg::res_t r;
	} row_t;

	row_t dir_table[$];
	plb_pkg::res_t exp_r;

	initial begin
		fails = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		reset_pool();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme handles, pages and slots, every command, repeated references
		dir_table.push_back('{mk_req(plb_pkg::CMD_REF, 0, 0, 5'd31, 0, 0), 1,
			mk_res(plb_pkg::ACT_DONE, 5'd31, 0, 0, 0, plb_pkg::ST_OK, 1)});
		dir_table.push_back('{mk_req(plb_pkg::CMD_LOAD, 16'hFFFF, 40'hFF_FFFF_FFFF, 0, 0, 0),
			0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_LOAD, 0, 0, 0, 0, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_LOAD, 16'hFFFF, 40'hFF_FFFF_FFFF, 0, 0, 0),
			0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_TOUCH, 0, 0, 5'd31, 0, 1), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_REL, 0, 0, 5'd30, 0, 1), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_REL, 0, 0, 5'd5, 0, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_SWAP, 0, 0, 5'd31, 5'd30, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_SWAP, 0, 0, 5'd3, 5'd3, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_FLUSH, 16'hFFFF, 0, 0, 0, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_TRUNC, 16'hFFFF, 40'd1, 0, 0, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_PURGE, 0, 0, 0, 0, 0), 0, '0});
		for (int i = 0; i < 8; i++)
			dir_table.push_back('{mk_req(plb_pkg::CMD_REF, 0, 0, 5'd7, 0, 0), 0, '0});
		dir_table.push_back('{mk_req(plb_pkg::CMD_TRUNC, 16'h5A5A, 40'hAA_5555_AAAA, 5'd21,
			5'd10, 1), 0, '0});
		foreach (dir_table[k]) begin
			send_request(dir_table[k].q);
			if (dir_table[k].has_res) begin
				exp_r = pending_results[$];
				if (exp_r !== dir_table[k].r) begin
					$display("%0t: table row %0d expected %h actual %h", $time, k,
						dir_table[k].r, exp_r);
					fails++;
				end
			end
		end
		// pin every slot so a load finds no victim, then release all
		for (int i = 0; i < NSLOT; i++)
			send_request(mk_req(plb_pkg::CMD_REF, 0, 0, 5'(i), 0, 0));
		send_request(mk_req(plb_pkg::CMD_LOAD, 16'h1234, 40'd99, 0, 0, 0));
		if (pending_results[$] !== mk_res(plb_pkg::ACT_DONE, 0, 16'h1234, 40'd99, 0,
				plb_pkg::ST_FULL, 1)) begin
			$display("%0t: full load expected %h actual %h", $time,
				mk_res(plb_pkg::ACT_DONE, 0, 16'h1234, 40'd99, 0, plb_pkg::ST_FULL, 1),
				pending_results[$]);
			fails++;
		end
		for (int i = 0; i < NSLOT; i++)
			while (pool_pins[i] != 0)
				send_request(mk_req(plb_pkg::CMD_REL, 0, 0, 5'(i), 0, 1));

		// hold off until everything is back
		drain_results();

		// random traffic through idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			for (int n = 0; n < 93; n++)
				send_request(random_request());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();

		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
